### rtl/core/tdsu_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package tdsu_pkg;

	localparam int FIFO_DEPTH = 64;
	localparam int PTR_W      = $clog2(FIFO_DEPTH);

	typedef logic [PTR_W-1:0] ptr_t;

	localparam ptr_t PTR_LAST = ptr_t'(FIFO_DEPTH - 1);

	// item codes
	localparam logic [1:0] MODE_TICK  = 2'd0;
	localparam logic [1:0] MODE_WRITE = 2'd1;
	localparam logic [1:0] MODE_READ  = 2'd2;

	// bit counter landmarks; the transmit engine uses all, the receive engine only BC_IDLE, BC_FIRST and BC_LAST_DATA
	localparam logic [3:0] BC_IDLE      = 4'd0;
	localparam logic [3:0] BC_FIRST     = 4'd1;
	localparam logic [3:0] BC_LAST_DATA = 4'd8;
	localparam logic [3:0] BC_STOP      = 4'd9;
	localparam logic [3:0] BC_GAP       = 4'd10;

	typedef struct packed {
		logic [1:0] mode;
		logic       rx_pin;
		logic [7:0] tx_byte;
	} cmd_t;

	typedef struct packed {
		logic       tx_pin;
		logic [7:0] rx_byte;
		logic       rx_byte_valid;
		logic       rx_available;
		logic       tx_accepted;
		logic       tx_busy;
		logic       rx_overflow;
	} res_t;

	typedef struct packed {
		logic line;
		logic busy;
		logic accepted;
	} tx_stat_t;

	typedef struct packed {
		logic byte_valid;
		logic available;
		logic overflow;
	} rx_stat_t;

	function automatic ptr_t ptr_next(input ptr_t p);
		return (p == PTR_LAST) ? '0 : p + 1'b1;
	endfunction

endpackage

`default_nettype wire

### rtl/core/tick_driven_soft_uart.sv
// Result path: an accepted item's status goes into stage 1, then into the output register.
// Throughput: one item per cycle while cmd_stall is low; each ring takes one pointer update
//   per cycle and answers a read from its registered RAM port, which bounds the rate.
// Reset: arst_n clears ring pointers, both bit engines, the transmit line (high) and the
//   overflow flag at once; ring contents are not cleared and need no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module tick_driven_soft_uart import tdsu_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic cmd_valid,
	output      logic cmd_stall,
	input  wire cmd_t cmd,
	output      logic res_valid,
	input  wire logic res_stall,
	output      res_t res
);

	// Each item updates both engines in its accept cycle. The status the item leaves is
	// captured in stage 1 while the receive ring read, if any, completes in the RAM. Stage 1
	// then moves into the output register, which picks up the RAM read data.

	logic     fire;
	logic     move;
	tx_stat_t tx_stat;
	rx_stat_t rx_stat;
	logic [7:0] rx_rdata;

	logic     valid_s1;
	tx_stat_t tx_s1;
	rx_stat_t rx_s1;

	res_t     res_q;
	logic     res_valid_q;

	// the output register frees up when empty or when its beat is taken
	assign move = !res_valid_q || !res_stall;

	// stage 1 and the output register act as a skid pair: stall only when both are full and res_stall holds
	assign cmd_stall = valid_s1 && !move;
	assign fire      = cmd_valid && !cmd_stall;

	tdsu_tx u_tx (
		.clk   (clk),
		.arst_n(arst_n),
		.fire  (fire),
		.cmd   (cmd),
		.stat  (tx_stat)
	);

	tdsu_rx u_rx (
		.clk   (clk),
		.arst_n(arst_n),
		.fire  (fire),
		.cmd   (cmd),
		.stat  (rx_stat),
		.rdata (rx_rdata)
	);

	// Stage 1: hold the status of the item whose ring read is in flight. While stage 1
	// waits no read is issued, so the RAM read data holds as well.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (fire) begin
			valid_s1 <= 1'b1;
		end else if (move) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			tx_s1 <= tx_stat;
			rx_s1 <= rx_stat;
		end
	end

	// Output register: advance stage 1 when free, drop the beat once taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (move) begin
			res_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (move && valid_s1) begin
			res_q.tx_pin        <= tx_s1.line;
			res_q.rx_byte       <= rx_s1.byte_valid ? rx_rdata : 8'd0;
			res_q.rx_byte_valid <= rx_s1.byte_valid;
			res_q.rx_available  <= rx_s1.available;
			res_q.tx_accepted   <= tx_s1.accepted;
			res_q.tx_busy       <= tx_s1.busy;
			res_q.rx_overflow   <= rx_s1.overflow;
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

	// a stage 1 beat is never overwritten while the output is blocked
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && res_valid && res_stall) |=> (valid_s1 && $stable(tx_s1) && $stable(rx_s1)))
		else $error("stage 1 beat lost under output stall");

	// a read and a write are never answered in the same beat
	a_one_kind: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> !(res.tx_accepted && res.rx_byte_valid))
		else $error("write and read reported together");

	// the line only leaves idle high inside a frame
	a_line_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && !res.tx_pin) |-> res.tx_busy)
		else $error("transmit line low while transmitter idle");

	// an empty read carries a zero byte
	a_empty_read: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && !res.rx_byte_valid) |-> (res.rx_byte == 8'd0))
		else $error("byte reported on a read that returned nothing");

endmodule

`default_nettype wire

### rtl/core/tdsu_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module tdsu_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output      logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// read data holds while no read is issued
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

### rtl/core/tdsu_tx.sv
`timescale 1ns / 1ps
`default_nettype none

module tdsu_tx import tdsu_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     fire,
	input  wire cmd_t     cmd,
	output      tx_stat_t stat
);

	ptr_t       wp_q, rp_q, wp_d, rp_d;
	logic       active_q, active_d;
	logic [7:0] shift_q, shift_d, shift_cur;
	logic [3:0] bc_q, bc_d;
	logic       line_q, line_d;
	logic       pend_q, pend_d;
	logic       we, re, accepted;
	logic [7:0] rdata;
	ptr_t       wp_nxt;

	tdsu_ram #(
		.WIDTH(8),
		.DEPTH(FIFO_DEPTH)
	) u_ring (
		.clk  (clk),
		.we   (we),
		.waddr(wp_q),
		.wdata(cmd.tx_byte),
		.re   (re),
		.raddr(rp_q),
		.rdata(rdata)
	);

	// a ring fetch arrives from the registered RAM read port the cycle after it is issued; the start bit never needs it
	assign shift_cur = pend_q ? rdata : shift_q;
	assign wp_nxt    = ptr_next(wp_q);

	always_comb begin
		wp_d     = wp_q;
		rp_d     = rp_q;
		active_d = active_q;
		shift_d  = shift_cur;
		bc_d     = bc_q;
		line_d   = line_q;
		pend_d   = 1'b0;
		we       = 1'b0;
		re       = 1'b0;
		accepted = 1'b0;
		if (fire) begin
			unique case (cmd.mode)
				MODE_TICK: begin
					if (active_q) begin
						priority if (bc_q == BC_IDLE) begin
							line_d = 1'b0;
							bc_d   = BC_FIRST;
						end else if (bc_q <= BC_LAST_DATA) begin
							line_d  = shift_cur[0];
							shift_d = {1'b0, shift_cur[7:1]};
							bc_d    = bc_q + 4'd1;
						end else if (bc_q == BC_STOP) begin
							line_d = 1'b1;
							bc_d   = BC_GAP;
						end else begin
							active_d = 1'b0;
							if (wp_q != rp_q) begin
								re       = 1'b1;
								pend_d   = 1'b1;
								rp_d     = ptr_next(rp_q);
								bc_d     = BC_IDLE;
								active_d = 1'b1;
							end
						end
					end
				end
				MODE_WRITE: begin
					if (wp_nxt != rp_q) begin
						we       = 1'b1;
						wp_d     = wp_nxt;
						accepted = 1'b1;
						// idle means empty: forward the byte straight in
						if (!active_q) begin
							shift_d  = cmd.tx_byte;
							rp_d     = ptr_next(rp_q);
							bc_d     = BC_IDLE;
							active_d = 1'b1;
						end
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q     <= '0;
			rp_q     <= '0;
			active_q <= 1'b0;
			shift_q  <= '0;
			bc_q     <= BC_IDLE;
			line_q   <= 1'b1;
			pend_q   <= 1'b0;
		end else begin
			wp_q     <= wp_d;
			rp_q     <= rp_d;
			active_q <= active_d;
			shift_q  <= shift_d;
			bc_q     <= bc_d;
			line_q   <= line_d;
			pend_q   <= pend_d;
		end
	end

	assign stat.line     = line_d;
	assign stat.busy     = active_d;
	assign stat.accepted = accepted;

endmodule

`default_nettype wire

### rtl/core/tdsu_rx.sv
`timescale 1ns / 1ps
`default_nettype none

module tdsu_rx import tdsu_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       fire,
	input  wire cmd_t       cmd,
	output      rx_stat_t   stat,
	output      logic [7:0] rdata
);

	ptr_t       wp_q, rp_q, wp_d, rp_d;
	logic [3:0] bc_q, bc_d;
	logic [7:0] shift_q, shift_d;
	logic       phase_q, phase_d;
	logic       ovf_q, ovf_d;
	logic       we, re, byte_valid;
	logic [2:0] bit_idx;
	ptr_t       wp_nxt;

	tdsu_ram #(
		.WIDTH(8),
		.DEPTH(FIFO_DEPTH)
	) u_ring (
		.clk  (clk),
		.we   (we),
		.waddr(wp_q),
		.wdata(shift_q),
		.re   (re),
		.raddr(rp_q),
		.rdata(rdata)
	);

	assign bit_idx = 3'(bc_q - 4'd1);
	assign wp_nxt  = ptr_next(wp_q);

	always_comb begin
		wp_d       = wp_q;
		rp_d       = rp_q;
		bc_d       = bc_q;
		shift_d    = shift_q;
		phase_d    = phase_q;
		ovf_d      = ovf_q;
		we         = 1'b0;
		re         = 1'b0;
		byte_valid = 1'b0;
		if (fire) begin
			unique case (cmd.mode)
				MODE_TICK: begin
					priority if (bc_q == BC_IDLE) begin
						if (!cmd.rx_pin) begin
							bc_d    = BC_FIRST;
							shift_d = '0;
							phase_d = 1'b0;
						end
					end else if (bc_q <= BC_LAST_DATA) begin
						if (phase_q) begin
							if (cmd.rx_pin) begin
								shift_d = shift_q | (8'd1 << bit_idx);
							end
							bc_d    = bc_q + 4'd1;
							phase_d = 1'b0;
						end else begin
							phase_d = 1'b1;
						end
					end else begin
						// stop bit: store on high, drop and flag when full
						if (phase_q) begin
							if (cmd.rx_pin) begin
								if (wp_nxt == rp_q) begin
									ovf_d = 1'b1;
								end else begin
									we   = 1'b1;
									wp_d = wp_nxt;
								end
							end
							bc_d = BC_IDLE;
						end else begin
							phase_d = 1'b1;
						end
					end
				end
				MODE_READ: begin
					if (wp_q != rp_q) begin
						re         = 1'b1;
						rp_d       = ptr_next(rp_q);
						byte_valid = 1'b1;
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q    <= '0;
			rp_q    <= '0;
			bc_q    <= BC_IDLE;
			shift_q <= '0;
			phase_q <= 1'b0;
			ovf_q   <= 1'b0;
		end else begin
			wp_q    <= wp_d;
			rp_q    <= rp_d;
			bc_q    <= bc_d;
			shift_q <= shift_d;
			phase_q <= phase_d;
			ovf_q   <= ovf_d;
		end
	end

	assign stat.byte_valid = byte_valid;
	assign stat.available  = (wp_d != rp_d);
	assign stat.overflow   = ovf_d;

endmodule

`default_nettype wire
